@@ hdl/vtpd_pkg.sv @@
// Package with shared constants, types and helpers for the vertex transform block.
`default_nettype none
package vtpd_pkg;
  localparam int FRAC_BITS = 16;
  localparam int NUM_REGS = 8;
  localparam int DIV_BITS = 32 + FRAC_BITS;
  localparam int DIV_STEPS = DIV_BITS + 1;
  localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] FX_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] FX_MIN = 32'sh80000000;

  typedef logic signed [31:0] fx_t;

  typedef enum logic [2:0] {
    REG_ROW0_COLS01 = 3'd0,
    REG_ROW0_COLS23 = 3'd1,
    REG_ROW1_COLS01 = 3'd2,
    REG_ROW1_COLS23 = 3'd3,
    REG_ROW2_COLS01 = 3'd4,
    REG_ROW2_COLS23 = 3'd5,
    REG_ROW3_COLS01 = 3'd6,
    REG_ROW3_COLS23 = 3'd7
  } reg_idx_t;

  typedef struct packed {
    fx_t c0;
    fx_t c1;
    fx_t c2;
    fx_t c3;
  } mrow_t;

  typedef struct packed {
    logic valid;
    logic stall;
  } flow_t;

  function automatic fx_t clamp_fx(input logic signed [49:0] v);
    if (v > 50'(FX_MAX)) begin
      return FX_MAX;
    end else if (v < 50'(FX_MIN)) begin
      return FX_MIN;
    end
    return v[31:0];
  endfunction

  function automatic logic clamp_hit(input logic signed [49:0] v);
    return (v > 50'(FX_MAX)) || (v < 50'(FX_MIN));
  endfunction
endpackage
`default_nettype wire

@@ hdl/vtpd_regs.sv @@
// Configuration register file holding the 4x4 matrix.
`default_nettype none
module vtpd_regs
  import vtpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  output mrow_t            rows [4]
);
  logic [63:0] regs [NUM_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[REG_ROW0_COLS01] <= 64'(ONE_FX);
      regs[REG_ROW0_COLS23] <= '0;
      regs[REG_ROW1_COLS01] <= {ONE_FX, 32'd0};
      regs[REG_ROW1_COLS23] <= '0;
      regs[REG_ROW2_COLS01] <= '0;
      regs[REG_ROW2_COLS23] <= 64'(ONE_FX);
      regs[REG_ROW3_COLS01] <= '0;
      regs[REG_ROW3_COLS23] <= {ONE_FX, 32'd0};
    end else if (cfg_valid) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      rows[r].c0 = regs[2*r][31:0];
      rows[r].c1 = regs[2*r][63:32];
      rows[r].c2 = regs[2*r+1][31:0];
      rows[r].c3 = regs[2*r+1][63:32];
    end
  end
endmodule
`default_nettype wire

@@ hdl/vtpd_xform.sv @@
// Pipelined matrix-vector product: multiply stage, then sum, shift and clamp stage.
`default_nettype none
module vtpd_xform
  import vtpd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic advance,
  input  wire logic in_valid,
  input  wire fx_t  px,
  input  wire fx_t  py,
  input  wire fx_t  pz,
  input  mrow_t     rows [4],
  output logic      out_valid,
  output fx_t       comp [4],
  output logic      sat
);
  logic               v1;
  logic signed [63:0] prod [4][3];
  fx_t                trans [4];
  logic signed [65:0] sum;
  logic signed [49:0] rsum;
  fx_t                comp_next [4];
  logic               sat_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int r = 0; r < 4; r++) begin
        prod[r][0] <= rows[r].c0 * px;
        prod[r][1] <= rows[r].c1 * py;
        prod[r][2] <= rows[r].c2 * pz;
        trans[r] <= rows[r].c3;
      end
      comp <= comp_next;
      sat <= sat_next;
    end
  end

  always_comb begin
    sat_next = 1'b0;
    sum = '0;
    rsum = '0;
    for (int r = 0; r < 4; r++) begin
      sum = 66'(prod[r][0]) + 66'(prod[r][1]) + 66'(prod[r][2]);
      rsum = 50'(sum >>> FRAC_BITS) + 50'(trans[r]);
      comp_next[r] = clamp_fx(rsum);
      sat_next = sat_next | clamp_hit(rsum);
    end
  end
endmodule
`default_nettype wire

@@ hdl/vtpd_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with clamp and select.
`default_nettype none
module vtpd_div
  import vtpd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic advance,
  input  wire logic in_valid,
  input  wire fx_t  comp [4],
  input  wire logic in_sat,
  output logic      out_valid,
  output fx_t       res [4],
  output logic      out_sat
);
  typedef struct packed {
    logic                     valid;
    logic                     do_div;
    logic                     sat;
    logic [31:0]              den;
    logic [2:0]               neg;
    logic [2:0][DIV_BITS-1:0] num;
    logic [2:0][DIV_BITS:0]   rem;
    logic [2:0][DIV_BITS-1:0] quo;
    fx_t                      w;
  } st_t;

  st_t st [DIV_STEPS];
  st_t st_next [DIV_STEPS];

  always_comb begin
    logic [DIV_BITS-1:0] mag;
    logic [DIV_BITS:0]   trial;
    logic [31:0]         wmag;
    mag = '0;
    trial = '0;
    wmag = comp[3][31] ? 32'(-comp[3]) : comp[3];
    st_next[0].valid = in_valid;
    st_next[0].do_div = (comp[3] != '0) && (comp[3] != ONE_FX);
    st_next[0].sat = in_sat;
    st_next[0].den = wmag;
    st_next[0].w = comp[3];
    st_next[0].rem = '0;
    st_next[0].quo = '0;
    for (int i = 0; i < 3; i++) begin
      mag = comp[i][31] ? DIV_BITS'(-$signed({{(DIV_BITS-32){comp[i][31]}}, comp[i]}))
                        : DIV_BITS'(comp[i]);
      st_next[0].num[i] = mag << FRAC_BITS;
      st_next[0].neg[i] = comp[i][31] ^ comp[3][31];
    end
    for (int s = 1; s < DIV_STEPS; s++) begin
      st_next[s] = st[s-1];
      for (int i = 0; i < 3; i++) begin
        trial = {st[s-1].rem[i][DIV_BITS-1:0], st[s-1].num[i][DIV_BITS-s]};
        if (trial >= (DIV_BITS+1)'(st[s-1].den)) begin
          st_next[s].rem[i] = trial - (DIV_BITS+1)'(st[s-1].den);
          st_next[s].quo[i] = {st[s-1].quo[i][DIV_BITS-2:0], 1'b1};
        end else begin
          st_next[s].rem[i] = trial;
          st_next[s].quo[i] = {st[s-1].quo[i][DIV_BITS-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DIV_STEPS; s++) begin
        st[s].valid <= 1'b0;
      end
    end else if (advance) begin
      st <= st_next;
    end
  end

  logic               v_q;
  fx_t                res_next [4];
  logic               sat_next;
  logic signed [49:0] q;
  st_t                last;

  always_comb begin
    last = st[DIV_STEPS-1];
    sat_next = last.sat;
    q = '0;
    for (int i = 0; i < 3; i++) begin
      if (last.do_div) begin
        q = last.neg[i] ? -$signed({2'b00, last.quo[i]}) : $signed({2'b00, last.quo[i]});
        res_next[i] = clamp_fx(q);
        sat_next = sat_next | clamp_hit(q);
      end else begin
        res_next[i] = 32'(last.num[i] >> FRAC_BITS);
        if (last.neg[i] ^ last.w[31]) begin
          res_next[i] = -res_next[i];
        end
      end
    end
    res_next[3] = last.do_div ? ONE_FX : last.w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= 1'b0;
    end else if (advance) begin
      v_q <= last.valid;
      res <= res_next;
      out_sat <= sat_next;
    end
  end
  assign out_valid = v_q;
endmodule
`default_nettype wire

@@ hdl/vertex_transform_perspective_divide_top.sv @@
// Top level of the vertex transform with perspective divide.
`default_nettype none
// Takes one point per cycle while the output is not stalled and returns x, y, z,
// w after a 4x4 transform and a divide by w (skipped when w is 0 or one), via a
// multiply stage, a sum and clamp stage, a 49-stage bit-per-stage divider and an
// output register. The whole pipeline holds when the output is stalled.
module vertex_transform_perspective_divide_top
  import vtpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire fx_t         point_x,
  input  wire fx_t         point_y,
  input  wire fx_t         point_z,
  output logic             out_valid,
  input  wire logic        out_stall,
  output fx_t              result_x,
  output fx_t              result_y,
  output fx_t              result_z,
  output fx_t              result_w,
  output logic             saturated
);
  mrow_t rows [4];
  logic  advance;
  logic  xv;
  fx_t   comp [4];
  logic  xsat;
  fx_t   res [4];

  assign advance = !(out_valid && out_stall);
  assign in_stall = !advance;
  assign cfg_ready = 1'b1;

  vtpd_regs u_regs (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .rows(rows)
  );

  vtpd_xform u_xform (
    .clk(clk), .rst(rst), .advance(advance), .in_valid(in_valid),
    .px(point_x), .py(point_y), .pz(point_z), .rows(rows),
    .out_valid(xv), .comp(comp), .sat(xsat)
  );

  vtpd_div u_div (
    .clk(clk), .rst(rst), .advance(advance), .in_valid(xv), .comp(comp),
    .in_sat(xsat), .out_valid(out_valid), .res(res), .out_sat(saturated)
  );

  assign result_x = res[0];
  assign result_y = res[1];
  assign result_z = res[2];
  assign result_w = res[3];

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_x) && $stable(result_w))
    else $error("stalled result changed");
  a_install: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output stalled");
  a_wone: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_w != ONE_FX |-> !saturated || result_w == 32'sd0)
    else $error("undivided result flagged with nonzero w");
`endif
endmodule
`default_nettype wire
